// ----- rtl/windowed_duplicate_detector_assert.svh -----
// Assertion macros for the duplicate detector.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef WINDOWED_DUPLICATE_DETECTOR_ASSERT_SVH
`define WINDOWED_DUPLICATE_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Check cons in the same cycle as ante.
`define WDD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wdd assertion failed");
// Check cons in the cycle after ante.
`define WDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wdd assertion failed");
`else
`define WDD_ASSERT_NOW(lbl, ante, cons)
`define WDD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/wdd_pkg.sv -----
package wdd_pkg;

  localparam int ValueW           = 32;
  localparam int WindowKW         = 5;
  localparam int DefaultMaxWindow = 16;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last_item;
  } wdd_in_t;

  typedef struct packed {
    logic match_now;
    logic found_so_far;
    logic array_done;
  } wdd_out_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic shift;   // an item transfer happens this cycle
    logic clear;   // that item closes the array
  } wdd_cell_ctrl_t;

endpackage

// ----- rtl/wdd_cell.sv -----
module wdd_cell
  import wdd_pkg::*;
#(
  parameter int CellIdx = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wdd_cell_ctrl_t           ctrl_i,
  input  logic [WindowKW-1:0]      window_k_i,
  input  logic signed [ValueW-1:0] probe_i,
  input  logic signed [ValueW-1:0] prev_value_i,
  input  logic                     prev_valid_i,
  output logic signed [ValueW-1:0] value_o,
  output logic                     valid_o,
  output logic                     hit_o
);

  logic signed [ValueW-1:0] value_q;
  logic                     valid_q;
  logic                     in_window;

  // Cell n holds the value n+1 positions back.
  assign in_window = (32'(CellIdx) < 32'(window_k_i));
  assign hit_o     = valid_q && in_window && (value_q == probe_i);
  assign value_o   = value_q;
  assign valid_o   = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= ctrl_i.clear ? 1'b0 : prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && !ctrl_i.clear) begin
      value_q <= prev_value_i;
    end
  end

endmodule

// ----- rtl/windowed_duplicate_detector.sv -----
// Sliding-window duplicate detector. Each transfer on the input carries one
// signed 32-bit value and a last_item mark; each produces exactly one result
// telling whether the value equals one of the previous window_k values of
// the same array (match_now), whether any such match has been seen in the
// array so far including this item (found_so_far), and whether this result
// closes the array (array_done). The history sits in a row of MAX_WINDOW
// cells that shift by one on every input transfer; every cell compares its
// value against the incoming one in parallel. A transfer with last_item set
// clears the history and the sticky flag after its result is formed.
// Throughput is one item per clock: the input stalls only while the output
// register holds a result and the output side stalls. The result is
// registered. The user must write window_k through cfg_we_i only while the
// block is idle; the block does not enforce this. Values above MAX_WINDOW
// saturate to MAX_WINDOW, and a new window applies from the next item on.
module windowed_duplicate_detector
  import wdd_pkg::*;
#(
  parameter int MAX_WINDOW = DefaultMaxWindow
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wdd_in_t             in_data_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wdd_out_t            out_data_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [WindowKW-1:0] cfg_wdata_i
);

`include "windowed_duplicate_detector_assert.svh"

  logic [WindowKW-1:0]      window_k_q;
  logic [WindowKW-1:0]      window_k_d;
  logic                     seen_q;
  logic                     seen_d;
  logic                     out_valid_q;
  wdd_out_t                 out_q;
  wdd_out_t                 out_d;
  logic                     in_xfer;
  logic                     hit_any;
  wdd_cell_ctrl_t           cell_ctrl;
  logic signed [ValueW-1:0] chain_value [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]    chain_valid;
  logic [MAX_WINDOW-1:0]    hit_vec;
  logic [MAX_WINDOW-1:0]    valid_inc;

  // Stall only while a finished result waits and the output side holds it.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign cell_ctrl.shift = in_xfer;
  assign cell_ctrl.clear = in_data_i.last_item;

  // Row of history cells: cell 0 takes the incoming value, each later cell
  // takes its left neighbor.
  for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
    logic signed [ValueW-1:0] prev_value;
    logic                     prev_valid;
    if (gi == 0) begin : g_head
      assign prev_value = in_data_i.value;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_value = chain_value[gi-1];
      assign prev_valid = chain_valid[gi-1];
    end
    wdd_cell #(
      .CellIdx(gi)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .window_k_i  (window_k_q),
      .probe_i     (in_data_i.value),
      .prev_value_i(prev_value),
      .prev_valid_i(prev_valid),
      .value_o     (chain_value[gi]),
      .valid_o     (chain_valid[gi]),
      .hit_o       (hit_vec[gi])
    );
  end

  assign hit_any = |hit_vec;

  // Form the result and the next sticky flag; drop the flag at array end.
  always_comb begin
    out_d.match_now    = hit_any;
    out_d.found_so_far = seen_q || hit_any;
    out_d.array_done   = in_data_i.last_item;
    seen_d             = in_data_i.last_item ? 1'b0 : (seen_q || hit_any);
  end

  // Saturate the written window at the number of cells.
  always_comb begin
    if (32'(cfg_wdata_i) > MAX_WINDOW) begin
      window_k_d = WindowKW'(MAX_WINDOW);
    end else begin
      window_k_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_k_q <= '0;
    end else if (cfg_we_i) begin
      window_k_q <= window_k_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_xfer) begin
      seen_q <= seen_d;
    end
  end

  // Output register: load on input transfer, release once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid cells always form a prefix starting at cell 0.
  assign valid_inc = chain_valid + MAX_WINDOW'(1);

  `WDD_ASSERT_NEXT(a_last_clears_row, in_xfer && in_data_i.last_item,
                   chain_valid == '0 && !seen_q)
  `WDD_ASSERT_NEXT(a_store_head, in_xfer && !in_data_i.last_item, chain_valid[0])
  `WDD_ASSERT_NOW(a_valid_prefix, 1'b1, (chain_valid & valid_inc) == '0)
  `WDD_ASSERT_NOW(a_match_sets_found, out_valid_q && out_q.match_now, out_q.found_so_far)
  `WDD_ASSERT_NOW(a_window_capped, 1'b1, 32'(window_k_q) <= MAX_WINDOW)

endmodule

// ----- tb/windowed_duplicate_detector_test.sv -----
`timescale 1ns / 100ps

module windowed_duplicate_detector_test
  import wdd_pkg::*;
;

  localparam int MaxWin     = DefaultMaxWindow;
  localparam int CycleLimit = 100000;
  localparam int Phases     = 10;
  localparam int PhaseItems = 60;

  // One pending entry: either an array element or a window_k write that
  // must wait until the block has drained.
  typedef struct {
    logic                is_cfg;
    logic [WindowKW-1:0] wdata;
    logic                calm;
    wdd_in_t             item;
  } stim_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  wdd_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  wdd_out_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [WindowKW-1:0] cfg_wdata_i = '0;

  windowed_duplicate_detector #(
    .MAX_WINDOW(MaxWin)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Entries waiting to be driven, and flags owed by the block.
  stim_t    pending[$];
  wdd_out_t owed_flags[$];

  // Shadow of the block: recent values (entry 0 newest), fill count,
  // sticky flag and the active window.
  logic [ValueW-1:0] history [MaxWin];
  int                fill_cnt   = 0;
  logic              seen       = 1'b0;
  int                window_len = 0;

  // Both sides stop idling while this is set.
  logic calm_phase = 1'b0;

  int gap_left      = 0;
  int stall_left    = 0;
  int fail_count    = 0;
  int cycle_count   = 0;
  int items_queued  = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int arrays_closed = 0;
  int hits_seen     = 0;
  int window_writes = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Compute the flags for one element and advance the shadow history.
  function automatic wdd_out_t predict_window_hit(wdd_in_t item);
    wdd_out_t r;
    int       span;
    int       i;
    logic     hit;
    span = (window_len < fill_cnt) ? window_len : fill_cnt;
    hit  = 1'b0;
    for (i = 0; i < span; i++) begin
      if (history[i] == item.value) hit = 1'b1;
    end
    seen           = seen | hit;
    r.match_now    = hit;
    r.found_so_far = seen;
    r.array_done   = item.last_item;
    if (item.last_item) begin
      // A closing element wipes the history and the sticky flag.
      fill_cnt = 0;
      seen     = 1'b0;
    end else begin
      for (i = MaxWin - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = item.value;
      if (fill_cnt < MaxWin) fill_cnt++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    fail_count++;
  endtask

  function automatic void add_item(logic [ValueW-1:0] value, logic last);
    stim_t s;
    s.is_cfg         = 1'b0;
    s.wdata          = '0;
    s.calm           = 1'b0;
    s.item.value     = value;
    s.item.last_item = last;
    pending.push_back(s);
    items_queued++;
  endfunction

  function automatic void add_window_write(logic [WindowKW-1:0] w, logic calm);
    stim_t s;
    s.is_cfg = 1'b1;
    s.wdata  = w;
    s.calm   = calm;
    s.item   = '0;
    pending.push_back(s);
  endfunction

  // Favor the sign and all-ones corners, otherwise any 32-bit pattern.
  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Driver: launch pending entries, record each accepted transfer in the
  // shadow, and hold window writes until no result is owed.
  always @(posedge clk_i) begin : drive
    logic                took;
    logic                held;
    logic                nxt_valid;
    logic                nxt_we;
    wdd_in_t             nxt_data;
    logic [WindowKW-1:0] nxt_wdata;
    stim_t               head;
    took      = in_valid_i && !in_stall_o;
    held      = in_valid_i && in_stall_o;
    nxt_valid = held;
    nxt_data  = in_data_i;
    nxt_we    = 1'b0;
    nxt_wdata = cfg_wdata_i;
    if (rst_ni) begin
      if (took) begin
        owed_flags.push_back(predict_window_hit(in_data_i));
        items_taken++;
      end
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          head = pending[0];
          if (!head.is_cfg) begin
            nxt_valid = 1'b1;
            nxt_data  = head.item;
            void'(pending.pop_front());
            gap_left = calm_phase ? 0 : $urandom_range(0, 4);
          end else if (!took && owed_flags.size() == 0 && !out_valid_o) begin
            // Block is drained: write the window, saturate the shadow copy.
            nxt_we     = 1'b1;
            nxt_wdata  = head.wdata;
            window_len = (head.wdata > MaxWin) ? MaxWin : int'(head.wdata);
            calm_phase = head.calm;
            window_writes++;
            void'(pending.pop_front());
          end
        end
      end
    end
    in_valid_i  <= nxt_valid;
    in_data_i   <= nxt_data;
    cfg_we_i    <= nxt_we;
    cfg_wdata_i <= nxt_wdata;
  end

  // Monitor: check each result transfer against the oldest owed flags and
  // draw a stall for the next one.
  always @(posedge clk_i) begin : observe
    wdd_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_flags.size() == 0) begin
          report_mismatch("result with nothing owed");
        end else begin
          want = owed_flags.pop_front();
          if (out_data_o.match_now !== want.match_now)
            report_mismatch($sformatf("match_now got %b want %b",
                                      out_data_o.match_now, want.match_now));
          if (out_data_o.found_so_far !== want.found_so_far)
            report_mismatch($sformatf("found_so_far got %b want %b",
                                      out_data_o.found_so_far, want.found_so_far));
          if (out_data_o.array_done !== want.array_done)
            report_mismatch($sformatf("array_done got %b want %b",
                                      out_data_o.array_done, want.array_done));
          if (want.array_done) arrays_closed++;
          if (want.match_now) hits_seen++;
        end
        results_seen++;
        stall_left = calm_phase ? 0 : $urandom_range(0, 4);
      end else if (stall_left > 0 && out_valid_o) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ValueW-1:0] pool [16];
    logic [ValueW-1:0] v;
    logic [WindowKW-1:0] w;
    int pool_n;
    int len;
    int made;
    int n;
    int j;

    // Directed part. A write above the cap must act as the full window.
    add_window_write(5'd31, 1'b0);
    // Extremes; the minimum repeats and hits; the first value is zero and
    // must not hit the cleared store.
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h7fff_ffff, 1'b0);
    add_item(32'hffff_ffff, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h0000_0001, 1'b1);
    // Zero right after a close: no hit; then a repeat at distance one.
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0000, 1'b1);
    // Window zero: nothing ever matches.
    add_window_write(5'd0, 1'b0);
    add_item(32'h0000_0007, 1'b0);
    add_item(32'h0000_0007, 1'b0);
    add_item(32'h0000_0007, 1'b1);
    // Shrink the window in the middle of an array.
    add_window_write(5'd16, 1'b0);
    add_item(32'h0000_0009, 1'b0);
    add_item(32'h0000_0008, 1'b0);
    add_window_write(5'd1, 1'b0);
    add_item(32'h0000_0009, 1'b0);
    add_item(32'h0000_0009, 1'b1);
    // Window one: distance two misses, distance one hits.
    add_item(32'h0000_0005, 1'b0);
    add_item(32'h0000_0006, 1'b0);
    add_item(32'h0000_0005, 1'b0);
    add_item(32'h0000_0005, 1'b1);

    // Random phases: arrays drawn from small value pools so that repeats
    // are common, some arrays long enough to overflow the history, some
    // noise, and a phase may end mid-array so the next window applies to
    // held history.
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0:       w = 5'd16;
        1:       w = 5'd0;
        2:       w = 5'd31;
        3:       w = 5'd1;
        4:       w = 5'd17;
        5:       w = 5'd2;
        6:       w = 5'd15;
        default: w = 5'($urandom_range(0, 31));
      endcase
      add_window_write(w, (ph == 3 || ph == 7));
      made = 0;
      while (made < PhaseItems) begin
        pool_n = $urandom_range(1, 16);
        for (j = 0; j < pool_n; j++) pool[j] = random_value();
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40)
                                          : $urandom_range(1, 12);
        n = 0;
        while (n < len && made < PhaseItems) begin
          v = ($urandom_range(0, 7) == 0) ? 32'($urandom())
                                          : pool[$urandom_range(0, pool_n - 1)];
          add_item(v, (n == len - 1));
          n++;
          made++;
        end
      end
    end

    // Release reset, then let the driver and monitor run.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every queued element has come back as a result.
    do @(posedge clk_i);
    while (results_seen < items_queued);
    repeat (5) @(posedge clk_i);

    $display("Checked %0d results for %0d transfers; %0d arrays closed, %0d window hits",
             results_seen, items_taken, arrays_closed, hits_seen);
    $display("Window register written %0d times, including 0, the cap and above it",
             window_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
